### hdl/lpmd_pkg.sv
// Shared types and constants for the length-prefixed message deframer.
package lpmd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam logic [LEN_W-1:0] MAX_BODY_RESET = 16'd4096;

    typedef struct packed {
        logic [BYTE_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_payload;
        logic              last;
        logic              error;
    } t_result;

endpackage

### hdl/lpmd_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
interface lpmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpmd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] kind;
    logic [7:0] payload_byte;
    logic       has_payload;
    logic       last;
    logic       error;

    modport source (output valid, output kind, output payload_byte, output has_payload,
                    output last, output error, input ready);
    modport sink   (input valid, input kind, input payload_byte, input has_payload,
                    input last, input error, output ready);
endinterface

### hdl/lpmd_front.sv
// Frame parser: tracks header phase and body count, emits result records.
module lpmd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lpmd_pkg::LEN_W-1:0]      i_cfg_wdata,
    input  logic                            i_take,
    input  logic [lpmd_pkg::BYTE_W-1:0]     i_byte,
    output logic                            o_push,
    output lpmd_pkg::t_result               o_res
);

    localparam logic [2:0] PH_LEN_HI  = 3'd0;
    localparam logic [2:0] PH_LEN_LO  = 3'd1;
    localparam logic [2:0] PH_KIND    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_FAILED  = 3'd4;

    logic [2:0]                        r_phase, n_phase;
    logic [lpmd_pkg::BYTE_W-1:0]       r_len_hi, n_len_hi;
    logic [lpmd_pkg::LEN_W-1:0]        r_remain, n_remain;
    logic [lpmd_pkg::BYTE_W-1:0]       r_kind, n_kind;
    logic [lpmd_pkg::LEN_W-1:0]        r_max_body;
    logic [lpmd_pkg::LEN_W-1:0]        len;
    logic                              rem_one;

    assign len     = {r_len_hi, i_byte};
    assign rem_one = (r_remain == lpmd_pkg::LEN_W'(1));

    always_comb begin
        n_phase  = r_phase;
        n_len_hi = r_len_hi;
        n_remain = r_remain;
        n_kind   = r_kind;
        o_push   = 1'b0;
        o_res    = '0;
        if (i_take) begin
            case (r_phase)
                PH_LEN_HI: begin
                    n_len_hi = i_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if ((len == '0) || (len > r_max_body)) begin
                        n_phase     = PH_FAILED;
                        o_push      = 1'b1;
                        o_res.error = 1'b1;
                    end else begin
                        n_remain = len;
                        n_phase  = PH_KIND;
                    end
                end
                PH_KIND: begin
                    n_kind   = i_byte;
                    n_remain = r_remain - lpmd_pkg::LEN_W'(1);
                    if (rem_one) begin
                        // body is the kind byte only: empty message marker
                        n_phase    = PH_LEN_HI;
                        o_push     = 1'b1;
                        o_res.kind = i_byte;
                        o_res.last = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_remain           = r_remain - lpmd_pkg::LEN_W'(1);
                    o_push             = 1'b1;
                    o_res.kind         = r_kind;
                    o_res.payload_byte = i_byte;
                    o_res.has_payload  = 1'b1;
                    o_res.last         = rem_one;
                    if (rem_one) begin
                        n_phase = PH_LEN_HI;
                    end
                end
                default: begin
                    // failed: drop everything until reset
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN_HI;
            r_len_hi   <= '0;
            r_remain   <= '0;
            r_kind     <= '0;
            r_max_body <= lpmd_pkg::MAX_BODY_RESET;
        end else begin
            r_phase  <= n_phase;
            r_len_hi <= n_len_hi;
            r_remain <= n_remain;
            r_kind   <= n_kind;
            if (i_cfg_we) begin
                r_max_body <= i_cfg_wdata;
            end
        end
    end

endmodule

### hdl/lpmd_queue.sv
// Short result queue between the parser and the output channel.
module lpmd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpmd_pkg::t_result i_res,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output lpmd_pkg::t_result o_res
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lpmd_pkg::t_result   r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wptr, r_rptr;
    logic [CNT_W-1:0]    r_count;
    logic                do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/length_prefixed_message_deframer_unit.sv
// Length-prefixed message deframer: takes bytes in and returns payload results.
// Each frame is a 16-bit big-endian body length, a kind byte, then payload bytes; the
// length counts the kind byte. One byte is taken every clock cycle while input ready is
// high: the parser updates its phase and body counter in the cycle the byte arrives and
// pushes any result into a short queue, whose registered head drives the output channel.
// Input ready drops only while the result queue is full. A zero length or a length above
// the max_body_size register (reset 4096) gives one error result, after which all bytes
// are dropped until reset. Writes to max_body_size take effect at the next length check.
module length_prefixed_message_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lpmd_pkg::LEN_W-1:0] i_cfg_wdata,
    lpmd_in_if.sink                    i_data_ch,
    lpmd_out_if.source                 o_res_ch
);

    logic              take;
    logic              push;
    logic              full;
    lpmd_pkg::t_result front_res;
    lpmd_pkg::t_result head_res;

    assign i_data_ch.ready = !full;
    assign take            = i_data_ch.valid && !full;

    lpmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_byte      (i_data_ch.data_byte),
        .o_push      (push),
        .o_res       (front_res)
    );

    lpmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (front_res),
        .o_full  (full),
        .o_valid (o_res_ch.valid),
        .i_pop   (o_res_ch.ready),
        .o_res   (head_res)
    );

    assign o_res_ch.kind         = head_res.kind;
    assign o_res_ch.payload_byte = head_res.payload_byte;
    assign o_res_ch.has_payload  = head_res.has_payload;
    assign o_res_ch.last         = head_res.last;
    assign o_res_ch.error        = head_res.error;

endmodule
